// ----- src/hmrd_pkg.sv -----
// ============================================================================
// hmrd_pkg
// Shared types and constants for the hid mouse report decoder
// ============================================================================
package hmrd_pkg;

    // queue depth between the report classifier and the chunk engine
    localparam int HMRD_QUEUE_DEPTH = 2;

    localparam int MOVE_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;

    localparam logic [7:0] PROTO_REPORT = 8'd0;
    localparam logic [7:0] PROTO_MOUSE  = 8'd2;

    localparam logic [7:0] REPORT_ID_MOTION = 8'd1;
    localparam logic [7:0] REPORT_ID_WHEEL  = 8'd2;

    localparam logic [LEN_W-1:0] LEN_WIDE_XY   = 7'd5;
    localparam logic [LEN_W-1:0] LEN_ID_MOTION = 7'd4;
    localparam logic [LEN_W-1:0] LEN_BOOT      = 7'd3;
    localparam logic [LEN_W-1:0] LEN_ID_WHEEL  = 7'd2;

    localparam logic signed [MOVE_W-1:0] CHUNK_POS = 12'sd127;
    localparam logic signed [MOVE_W-1:0] CHUNK_NEG = -12'sd127;

    typedef logic signed [MOVE_W-1:0] move_t;

    // one decoded report, waiting to be split into mouse items
    typedef struct packed {
        logic                     is_wheel;
        logic [BYTE_W-1:0]        buttons;
        move_t                    dx;
        move_t                    dy;
        logic signed [BYTE_W-1:0] wheel;
    } cmd_t;

endpackage

// ----- src/hmrd_if.sv -----
// ============================================================================
// hmrd report and mouse channels
// Valid/ready channels carrying raw hid reports in and mouse items out
// ============================================================================
interface hmrd_report_if;
    logic       valid;
    logic       ready;
    logic       is_hid_class;
    logic [7:0] interface_protocol;
    logic [6:0] report_length;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;

    modport source (
        output valid, is_hid_class, interface_protocol, report_length,
               byte0, byte1, byte2, byte3, byte4,
        input  ready
    );
    modport sink (
        input  valid, is_hid_class, interface_protocol, report_length,
               byte0, byte1, byte2, byte3, byte4,
        output ready
    );
endinterface

interface hmrd_mouse_if;
    logic              valid;
    logic              ready;
    logic [7:0]        buttons;
    logic [7:0]        prev_buttons;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel;
    logic              last;

    modport source (
        output valid, buttons, prev_buttons, move_x, move_y, wheel, last,
        input  ready
    );
    modport sink (
        input  valid, buttons, prev_buttons, move_x, move_y, wheel, last,
        output ready
    );
endinterface

// ----- src/hid_mouse_report_decoder_top.sv -----
// ============================================================================
// hid_mouse_report_decoder_top
// Decodes hid mouse reports into a stream of clamped mouse motion items
// ============================================================================
//
//   channel  role    carries
//   -------  ------  ----------------------------------------------------
//   report   sink    raw report: class flag, protocol, length, bytes 0-4
//   mouse    source  buttons, prev_buttons, move_x/y, wheel, last
//
// a report is taken and queued; the chunk engine then issues one mouse item
// per cycle while the mouse side is ready, 1 to 17 items per report (ceil of
// |move|/127 over the larger axis), with a pass through its idle state to load each queued command.
// rejected or too-short reports give no item and cost only their accept.
// reset clears the queue, the engine and the remembered buttons.
// either side may stall: the queue and the output register decouple them.
//
module hid_mouse_report_decoder_top #(
    parameter int QUEUE_DEPTH = hmrd_pkg::HMRD_QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    hmrd_report_if.sink  report,
    hmrd_mouse_if.source mouse
);

    logic           q_full;
    logic           q_push;
    hmrd_pkg::cmd_t q_push_cmd;
    logic           q_pop;
    hmrd_pkg::cmd_t q_pop_cmd;
    logic           q_empty;

    hmrd_front u_front (
        .report (report),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    hmrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    hmrd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_pop_cmd),
        .q_pop   (q_pop),
        .mouse   (mouse)
    );

endmodule

// ----- src/hmrd_front.sv -----
// ============================================================================
// hmrd_front
// Accepts raw reports, picks the parsing and pushes a decoded command
// ============================================================================
module hmrd_front (
    hmrd_report_if.sink    report,
    input  logic           q_full,
    output logic           q_push,
    output hmrd_pkg::cmd_t q_cmd
);

    logic accept;
    logic proto_ok;
    logic wide_xy;
    logic id_motion;
    logic id_wheel;
    logic boot;

    assign report.ready = !q_full;
    assign accept       = report.valid && !q_full;

    assign proto_ok  = report.is_hid_class
                     && (report.interface_protocol == hmrd_pkg::PROTO_REPORT
                      || report.interface_protocol == hmrd_pkg::PROTO_MOUSE);
    assign wide_xy   = report.report_length == hmrd_pkg::LEN_WIDE_XY;
    assign id_motion = report.report_length >= hmrd_pkg::LEN_ID_MOTION
                     && report.byte0 == hmrd_pkg::REPORT_ID_MOTION;
    assign id_wheel  = report.report_length >= hmrd_pkg::LEN_ID_WHEEL
                     && report.byte0 == hmrd_pkg::REPORT_ID_WHEEL;
    assign boot      = report.report_length >= hmrd_pkg::LEN_BOOT;

    always_comb
    begin
        q_cmd.is_wheel = 1'b0;
        q_cmd.buttons  = report.byte0;
        q_cmd.dx       = {{4{report.byte1[7]}}, report.byte1};
        q_cmd.dy       = {{4{report.byte2[7]}}, report.byte2};
        q_cmd.wheel    = report.byte1;
        q_push         = 1'b0;
        if (wide_xy)
        begin
            // 12-bit x and y packed across bytes 1 to 3
            q_cmd.dx = {report.byte2[3:0], report.byte1};
            q_cmd.dy = {report.byte3, report.byte2[7:4]};
            q_push   = accept && proto_ok;
        end
        else if (id_motion)
        begin
            q_cmd.buttons = report.byte1;
            q_cmd.dx      = {{4{report.byte2[7]}}, report.byte2};
            q_cmd.dy      = {{4{report.byte3[7]}}, report.byte3};
            q_push        = accept && proto_ok;
        end
        else if (id_wheel)
        begin
            q_cmd.is_wheel = 1'b1;
            q_cmd.dx       = '0;
            q_cmd.dy       = '0;
            q_push         = accept && proto_ok;
        end
        else if (boot)
        begin
            q_push = accept && proto_ok;
        end
    end

endmodule

// ----- src/hmrd_queue.sv -----
// ============================================================================
// hmrd_queue
// Small command queue between the classifier and the chunk engine
// ============================================================================
module hmrd_queue #(
    parameter int DEPTH = hmrd_pkg::HMRD_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hmrd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output hmrd_pkg::cmd_t pop_cmd,
    output logic           empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hmrd_pkg::cmd_t   entry_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/hmrd_back.sv -----
// ============================================================================
// hmrd_back
// Splits a decoded command into clamped motion chunks and drives the output
// ============================================================================
module hmrd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  hmrd_pkg::cmd_t q_cmd,
    output logic           q_pop,
    hmrd_mouse_if.source   mouse
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                is_wheel_reg;
    logic [7:0]          btn_reg;
    hmrd_pkg::move_t     rest_x_reg;
    hmrd_pkg::move_t     rest_y_reg;
    logic signed [7:0]   whl_reg;
    logic [7:0]          last_btn_reg;
    logic                is_wheel_next;
    logic [7:0]          btn_next;
    hmrd_pkg::move_t     rest_x_next;
    hmrd_pkg::move_t     rest_y_next;
    logic signed [7:0]   whl_next;
    logic [7:0]          last_btn_next;

    logic                out_valid_reg;
    logic [7:0]          out_btn_reg;
    logic [7:0]          out_prev_reg;
    logic signed [7:0]   out_x_reg;
    logic signed [7:0]   out_y_reg;
    logic signed [7:0]   out_whl_reg;
    logic                out_last_reg;
    logic                out_valid_next;
    logic [7:0]          out_btn_next;
    logic [7:0]          out_prev_next;
    logic signed [7:0]   out_x_next;
    logic signed [7:0]   out_y_next;
    logic signed [7:0]   out_whl_next;
    logic                out_last_next;

    logic                emit;
    logic signed [7:0]   chunk_x;
    logic signed [7:0]   chunk_y;
    hmrd_pkg::move_t     left_x;
    hmrd_pkg::move_t     left_y;

    assign emit  = (state_reg == ST_RUN) && (!out_valid_reg || mouse.ready);
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    // clamp each axis to one chunk, what is left carries to the next item
    always_comb
    begin
        if (rest_x_reg > hmrd_pkg::CHUNK_POS)
        begin
            chunk_x = 8'sd127;
        end
        else if (rest_x_reg < hmrd_pkg::CHUNK_NEG)
        begin
            chunk_x = -8'sd127;
        end
        else
        begin
            chunk_x = rest_x_reg[7:0];
        end
        if (rest_y_reg > hmrd_pkg::CHUNK_POS)
        begin
            chunk_y = 8'sd127;
        end
        else if (rest_y_reg < hmrd_pkg::CHUNK_NEG)
        begin
            chunk_y = -8'sd127;
        end
        else
        begin
            chunk_y = rest_y_reg[7:0];
        end
        left_x = rest_x_reg - {{4{chunk_x[7]}}, chunk_x};
        left_y = rest_y_reg - {{4{chunk_y[7]}}, chunk_y};
    end

    always_comb
    begin
        state_next     = state_reg;
        is_wheel_next  = is_wheel_reg;
        btn_next       = btn_reg;
        rest_x_next    = rest_x_reg;
        rest_y_next    = rest_y_reg;
        whl_next       = whl_reg;
        last_btn_next  = last_btn_reg;
        out_valid_next = out_valid_reg && !mouse.ready;
        out_btn_next   = out_btn_reg;
        out_prev_next  = out_prev_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_whl_next   = out_whl_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    is_wheel_next = q_cmd.is_wheel;
                    btn_next      = q_cmd.buttons;
                    rest_x_next   = q_cmd.dx;
                    rest_y_next   = q_cmd.dy;
                    whl_next      = q_cmd.wheel;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_prev_next  = last_btn_reg;
                    if (is_wheel_reg)
                    begin
                        // wheel report leaves the button history alone
                        out_btn_next  = last_btn_reg;
                        out_x_next    = '0;
                        out_y_next    = '0;
                        out_whl_next  = whl_reg;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_btn_next  = btn_reg;
                        out_x_next    = chunk_x;
                        out_y_next    = chunk_y;
                        out_whl_next  = '0;
                        out_last_next = (left_x == '0) && (left_y == '0);
                        last_btn_next = btn_reg;
                        rest_x_next   = left_x;
                        rest_y_next   = left_y;
                        if ((left_x == '0) && (left_y == '0))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            is_wheel_reg  <= 1'b0;
            btn_reg       <= '0;
            rest_x_reg    <= '0;
            rest_y_reg    <= '0;
            whl_reg       <= '0;
            last_btn_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_btn_reg   <= '0;
            out_prev_reg  <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_whl_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_wheel_reg  <= is_wheel_next;
            btn_reg       <= btn_next;
            rest_x_reg    <= rest_x_next;
            rest_y_reg    <= rest_y_next;
            whl_reg       <= whl_next;
            last_btn_reg  <= last_btn_next;
            out_valid_reg <= out_valid_next;
            out_btn_reg   <= out_btn_next;
            out_prev_reg  <= out_prev_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_whl_reg   <= out_whl_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign mouse.valid        = out_valid_reg;
    assign mouse.buttons      = out_btn_reg;
    assign mouse.prev_buttons = out_prev_reg;
    assign mouse.move_x       = out_x_reg;
    assign mouse.move_y       = out_y_reg;
    assign mouse.wheel        = out_whl_reg;
    assign mouse.last         = out_last_reg;

endmodule
